// ===== sv/csvp_pkg.sv =====
// Shared constants, tables and helper functions of the CSV telemetry line parser.
package csvp_pkg;

  // Parse phases of one line.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_MINUS  = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_POST   = 3'd4;

  // Numeric field types.
  localparam logic [2:0] FT_U16  = 3'd0;
  localparam logic [2:0] FT_S16  = 3'd1;
  localparam logic [2:0] FT_S32  = 3'd2;
  localparam logic [2:0] FT_FLAG = 3'd3;
  localparam logic [2:0] FT_MASK = 3'd4;

  // Message kinds.
  localparam logic [1:0] KIND_SETPOINT = 2'd0;
  localparam logic [1:0] KIND_SP_ACK   = 2'd1;
  localparam logic [1:0] KIND_ACTUAL   = 2'd2;
  localparam logic [1:0] KIND_ULTRA    = 2'd3;

  localparam int NUM_KINDS  = 4;
  localparam int NUM_FIELDS = 8;
  localparam int HDR_MAX    = 8;

  // Characters recognized by the parser.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Header text of each kind, padded with zero bytes.
  localparam logic [7:0] HDR_TEXT [NUM_KINDS][HDR_MAX] = '{
    '{"V", "S", "O", "L", ",", 8'h00, 8'h00, 8'h00},
    '{"V", "S", "O", "L", "_", "O", "K", ","},
    '{"V", "I", "S", "T", ",", 8'h00, 8'h00, 8'h00},
    '{"U", "S", ",", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] HDR_LEN [NUM_KINDS] = '{4'd5, 4'd8, 4'd5, 4'd3};

  // Length of the common prefix of two headers.
  localparam logic [3:0] HDR_CPL [NUM_KINDS][NUM_KINDS] = '{
    '{4'd5, 4'd4, 4'd1, 4'd0},
    '{4'd4, 4'd8, 4'd1, 4'd0},
    '{4'd1, 4'd1, 4'd5, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd3}
  };

  localparam logic [3:0] FIELD_COUNT [NUM_KINDS] = '{4'd4, 4'd1, 4'd7, 4'd8};

  localparam logic [2:0] FIELD_TYPE [NUM_KINDS][NUM_FIELDS] = '{
    '{FT_U16, FT_FLAG, FT_S16, FT_S16, FT_U16, FT_U16, FT_U16, FT_U16},
    '{FT_U16, FT_U16, FT_U16, FT_U16, FT_U16, FT_U16, FT_U16, FT_U16},
    '{FT_U16, FT_S16, FT_S16, FT_S16, FT_S16, FT_S32, FT_S32, FT_U16},
    '{FT_U16, FT_U16, FT_U16, FT_U16, FT_MASK, FT_U16, FT_U16, FT_U16}
  };

  // Largest magnitude a field of the given type may reach.
  function automatic logic [31:0] field_limit(input logic [2:0] ftype, input logic neg);
    logic [31:0] lim;
    case (ftype)
      FT_S16:  lim = neg ? 32'd32768 : 32'd32767;
      FT_S32:  lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      FT_FLAG: lim = 32'd1;
      FT_MASK: lim = 32'd7;
      default: lim = 32'd65535;
    endcase
    return lim;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== sv/csvp_in_if.sv =====
// Input channel: one character or terminator per item, with valid/ready handshake.
interface csvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

// ===== sv/csvp_out_if.sv =====
// Result channel: one parsed line per item, with valid/ready handshake.
interface csvp_out_if;
  logic               valid;
  logic               ready;
  logic               line_valid;
  logic        [1:0]  msg_kind;
  logic signed [31:0] value_0;
  logic signed [31:0] value_1;
  logic signed [31:0] value_2;
  logic signed [31:0] value_3;
  logic signed [31:0] value_4;
  logic signed [31:0] value_5;
  logic signed [31:0] value_6;
  logic signed [31:0] value_7;

  modport source (output valid, output line_valid, output msg_kind,
                  output value_0, output value_1, output value_2, output value_3,
                  output value_4, output value_5, output value_6, output value_7,
                  input ready);
  modport sink (input valid, input line_valid, input msg_kind,
                input value_0, input value_1, input value_2, input value_3,
                input value_4, input value_5, input value_6, input value_7,
                output ready);
endinterface

// ===== sv/csv_telemetry_line_parser.sv =====
// Top level of the CSV telemetry line parser: header match, field scan and result register.
//
// Usage: the in_ch channel carries one ASCII character per item; an item with
// line_end set is the terminator and ends the line. The parser recognizes the
// four message headers, scans the comma-separated decimal fields with range
// checks on every digit, and on the terminator produces one item on out_ch
// with line_valid, msg_kind and up to eight field values (zero when unused or
// when the line is invalid). Characters other than the terminator produce no
// result.
// The result appears on out_ch in the cycle after the terminator is accepted.
// Throughput: one item per cycle unless stalled; each character is folded into
// the parse state (compare plus multiply-by-ten accumulate).
// Stall: a waiting result sits in the output register; in_ch.ready stays high
// as long as that register is empty or being taken in the same cycle, so a
// stalled receiver holds off input only once a result is pending.
// Reset: rst_n is synchronous and active low; it drops any pending result and
// returns the parser to header matching with all fields cleared.
module csv_telemetry_line_parser (
  input  logic      clk,
  input  logic      rst_n,
  csvp_in_if.sink   in_ch,
  csvp_out_if.source out_ch
);
  import csvp_pkg::*;

  // Parse state.
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hpos_r, hpos_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic        minus_r, minus_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [31:0] store_r [NUM_FIELDS];
  logic [31:0] store_nxt [NUM_FIELDS];
  logic        failed_r, failed_nxt;

  // Result register.
  logic        out_valid_r;
  logic        out_line_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_val_r [NUM_FIELDS];

  logic        in_fire;
  logic        end_fire;
  logic        line_ok;
  logic [7:0]  ch;
  logic [2:0]  cur_type;
  logic [35:0] acc;
  logic        over_limit;
  logic [3:0]  fidx_inc;
  logic        last_field;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign end_fire    = in_fire && in_ch.line_end;
  assign ch          = in_ch.char_in;

  // Field type and digit accumulate for the current field.
  assign cur_type   = FIELD_TYPE[kind_r][fidx_r];
  assign acc        = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {32'd0, ch[3:0]};
  assign over_limit = acc > {4'd0, field_limit(cur_type, minus_r)};
  assign fidx_inc   = {1'b0, fidx_r} + 4'd1;
  assign last_field = fidx_inc >= FIELD_COUNT[kind_r];

  // The line is complete when the last field has at least one digit.
  assign line_ok = !failed_r && ((phase_r == PH_DIGITS) || (phase_r == PH_POST)) &&
                   (fidx_inc == FIELD_COUNT[kind_r]);

  // Next parse state for one accepted character.
  always_comb begin
    logic found;
    logic cand_ok;
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    kind_nxt   = kind_r;
    fidx_nxt   = fidx_r;
    minus_nxt  = minus_r;
    mag_nxt    = mag_r;
    failed_nxt = failed_r;
    found      = 1'b0;
    cand_ok    = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      store_nxt[i] = store_r[i];
    end

    if (end_fire) begin
      // Terminator: start the next line from scratch.
      phase_nxt  = PH_HEADER;
      hpos_nxt   = 4'd0;
      kind_nxt   = KIND_SETPOINT;
      fidx_nxt   = 3'd0;
      minus_nxt  = 1'b0;
      mag_nxt    = 32'd0;
      failed_nxt = 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        store_nxt[i] = 32'd0;
      end
    end else if (in_fire && !failed_r) begin
      unique case (phase_r) inside
        PH_HEADER: begin
          // First header, in list order, that agrees with the prefix seen so far.
          for (int k = 0; k < NUM_KINDS; k++) begin
            cand_ok = (hpos_r < HDR_LEN[k]) &&
                      ((hpos_r == 4'd0) ||
                       ((hpos_r < HDR_LEN[kind_r]) && (HDR_CPL[k][kind_r] >= hpos_r))) &&
                      (HDR_TEXT[k][hpos_r[2:0]] == ch);
            if (cand_ok && !found) begin
              found    = 1'b1;
              kind_nxt = k[1:0];
              hpos_nxt = hpos_r + 4'd1;
              if ((hpos_r + 4'd1) == HDR_LEN[k]) begin
                phase_nxt = PH_PRE;
              end
            end
          end
          if (!found) begin
            failed_nxt = 1'b1;
          end
        end
        PH_PRE, PH_MINUS, PH_DIGITS, PH_POST: begin
          if (is_digit(ch) && (phase_r != PH_POST)) begin
            // Digit: accumulate unless the field limit would be passed.
            if (over_limit) begin
              failed_nxt = 1'b1;
            end else begin
              mag_nxt           = acc[31:0];
              store_nxt[fidx_r] = minus_r ? (32'd0 - acc[31:0]) : acc[31:0];
              phase_nxt         = PH_DIGITS;
            end
          end else if (is_space(ch) && (phase_r != PH_MINUS)) begin
            if (phase_r == PH_DIGITS) begin
              phase_nxt = PH_POST;
            end
          end else if ((ch == CH_MINUS) && (phase_r == PH_PRE) &&
                       ((cur_type == FT_S16) || (cur_type == FT_S32))) begin
            minus_nxt = 1'b1;
            phase_nxt = PH_MINUS;
          end else if ((ch == CH_COMMA) &&
                       ((phase_r == PH_DIGITS) || (phase_r == PH_POST))) begin
            // Comma: move to the next field if the kind has one.
            if (last_field) begin
              failed_nxt = 1'b1;
            end else begin
              fidx_nxt  = fidx_inc[2:0];
              minus_nxt = 1'b0;
              mag_nxt   = 32'd0;
              phase_nxt = PH_PRE;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= 4'd0;
      kind_r   <= KIND_SETPOINT;
      fidx_r   <= 3'd0;
      minus_r  <= 1'b0;
      mag_r    <= 32'd0;
      failed_r <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        store_r[i] <= 32'd0;
      end
    end else begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      kind_r   <= kind_nxt;
      fidx_r   <= fidx_nxt;
      minus_r  <= minus_nxt;
      mag_r    <= mag_nxt;
      failed_r <= failed_nxt;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded on the terminator item.
  always_ff @(posedge clk) begin
    if (end_fire) begin
      out_line_valid_r <= line_ok;
      out_kind_r       <= line_ok ? kind_r : KIND_SETPOINT;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        out_val_r[i] <= line_ok ? store_r[i] : 32'd0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_valid = out_line_valid_r;
  assign out_ch.msg_kind   = out_kind_r;
  assign out_ch.value_0    = out_val_r[0];
  assign out_ch.value_1    = out_val_r[1];
  assign out_ch.value_2    = out_val_r[2];
  assign out_ch.value_3    = out_val_r[3];
  assign out_ch.value_4    = out_val_r[4];
  assign out_ch.value_5    = out_val_r[5];
  assign out_ch.value_6    = out_val_r[6];
  assign out_ch.value_7    = out_val_r[7];

  // A terminator always leaves the parser back at the start of a clean line.
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (phase_r == PH_HEADER) && (hpos_r == 4'd0) && !failed_r)
    else $error("parser did not restart after terminator");

  // A new result only follows an accepted terminator.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(end_fire))
    else $error("result appeared without a terminator");

  // An invalid line reports kind zero and zero fields (fields 0 and 7 are checked).
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_line_valid_r) |->
      (out_kind_r == KIND_SETPOINT) && (out_val_r[0] == 32'd0) && (out_val_r[7] == 32'd0))
    else $error("invalid line carries nonzero payload");

  // The field index never runs past the last field of the current kind.
  a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (fidx_inc <= FIELD_COUNT[kind_r]))
    else $error("field index beyond field count");

endmodule

// ===== tb/csv_telemetry_line_parser_tb.sv =====
// Self-checking testbench of the CSV telemetry line parser: directed lines, then random lines.
module csv_telemetry_line_parser_tb;
  import csvp_pkg::*;

  // One parsed line as it leaves the block.
  typedef struct packed {
    logic             line_valid;
    logic [1:0]       msg_kind;
    logic [0:7][31:0] value;
  } line_result_t;

  // One directed line; the expected result is typed in only where it is obvious.
  typedef struct {
    string        text;
    int           nul_at;
    bit           typed;
    line_result_t want;
  } line_row_t;

  localparam string NOISE_CHARS = "VSOLIKTU_,-0123456789 \t";

  logic clk = 1'b0;
  logic rst_n;

  csvp_in_if  in_ch ();
  csvp_out_if out_ch ();

  csv_telemetry_line_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Parser state as the block should hold it.
  logic [2:0]  ln_phase;
  logic [3:0]  ln_hpos;
  logic [1:0]  ln_kind;
  logic [3:0]  ln_fidx;
  logic        ln_neg;
  logic [31:0] ln_mag;
  logic [31:0] ln_fields [8];
  logic        ln_failed;

  line_result_t expected_lines [$];
  line_row_t    dir_rows [$];
  logic [7:0]   line_buf [$];

  bit           row_typed;
  line_result_t row_want;
  bit           tx_burst;
  bit           rx_burst;
  bit           rx_hold = 1'b0;
  bit           start_hold = 1'b0;

  int n_mismatch = 0;
  int n_checked = 0;
  int n_lines_sent = 0;
  int n_chars = 0;
  int n_rejected = 0;
  int n_kind_ok [4] = '{0, 0, 0, 0};

  // Free-running clock, period 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 30) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_line_state();
    ln_phase  = PH_HEADER;
    ln_hpos   = '0;
    ln_kind   = KIND_SETPOINT;
    ln_fidx   = '0;
    ln_neg    = 1'b0;
    ln_mag    = '0;
    ln_failed = 1'b0;
    for (int i = 0; i < 8; i++) ln_fields[i] = '0;
  endtask

  // Largest magnitude a field may spell, given its type and sign.
  function automatic longint magnitude_cap(input logic [2:0] ftype, input logic neg);
    if (ftype == FT_FLAG) return 1;
    if (ftype == FT_MASK) return 7;
    if (ftype == FT_S16) return neg ? 32768 : 32767;
    if (ftype == FT_S32) return neg ? 64'sd2147483648 : 64'sd2147483647;
    return 65535;
  endfunction

  // Header matching: follow the first header that still agrees with what came so far.
  task automatic match_header(input logic [7:0] c);
    bit found;
    bit same;
    found = 1'b0;
    for (int k = 0; k < NUM_KINDS && !found; k++) begin
      if (ln_hpos < HDR_LEN[k]) begin
        same = 1'b1;
        if (ln_hpos > 0) begin
          if (ln_hpos >= HDR_LEN[ln_kind]) same = 1'b0;
          for (int j = 0; j < ln_hpos; j++) begin
            if (HDR_TEXT[k][j] != HDR_TEXT[ln_kind][j]) same = 1'b0;
          end
        end
        if (same && HDR_TEXT[k][ln_hpos[2:0]] == c) begin
          found = 1'b1;
          ln_kind = 2'(k);
          if (ln_hpos + 4'd1 == HDR_LEN[k]) ln_phase = PH_PRE;
          ln_hpos = ln_hpos + 4'd1;
        end
      end
    end
    if (!found) ln_failed = 1'b1;
  endtask

  // Fold one digit in, rejecting it as soon as the field's range is exceeded.
  task automatic add_digit(input logic [7:0] c);
    longint acc;
    acc = longint'(ln_mag) * 10 + longint'(c - CH_ZERO);
    if (acc > magnitude_cap(FIELD_TYPE[ln_kind][ln_fidx[2:0]], ln_neg)) begin
      ln_failed = 1'b1;
    end else begin
      ln_mag = acc[31:0];
      ln_fields[ln_fidx[2:0]] = ln_neg ? (32'd0 - ln_mag) : ln_mag;
      ln_phase = PH_DIGITS;
    end
  endtask

  task automatic advance_field();
    if (int'(ln_fidx) + 1 >= int'(FIELD_COUNT[ln_kind])) begin
      ln_failed = 1'b1;
    end else begin
      ln_fidx  = ln_fidx + 4'd1;
      ln_neg   = 1'b0;
      ln_mag   = '0;
      ln_phase = PH_PRE;
    end
  endtask

  // Field scanning after the header.
  task automatic scan_body(input logic [7:0] c);
    logic [2:0] ft;
    logic       dig;
    logic       blank;
    ft    = FIELD_TYPE[ln_kind][ln_fidx[2:0]];
    dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    blank = (c == CH_SPACE) || (c == CH_TAB);
    case (ln_phase)
      PH_PRE: begin
        if (!blank) begin
          if (c == CH_MINUS && (ft == FT_S16 || ft == FT_S32)) begin
            ln_neg   = 1'b1;
            ln_phase = PH_MINUS;
          end else if (dig) begin
            add_digit(c);
          end else begin
            ln_failed = 1'b1;
          end
        end
      end
      PH_MINUS: begin
        if (dig) add_digit(c);
        else ln_failed = 1'b1;
      end
      PH_DIGITS: begin
        if (dig) add_digit(c);
        else if (blank) ln_phase = PH_POST;
        else if (c == CH_COMMA) advance_field();
        else ln_failed = 1'b1;
      end
      PH_POST: begin
        if (!blank) begin
          if (c == CH_COMMA) advance_field();
          else ln_failed = 1'b1;
        end
      end
      default: ln_failed = 1'b1;
    endcase
  endtask

  // Apply one accepted item; a terminator queues the line's expected result.
  task automatic predict_item(input logic [7:0] c, input logic le);
    line_result_t res;
    bit ok;
    if (le) begin
      ok = !ln_failed && (ln_phase == PH_DIGITS || ln_phase == PH_POST) &&
           (int'(ln_fidx) + 1 == int'(FIELD_COUNT[ln_kind]));
      res = '0;
      if (ok) begin
        res.line_valid = 1'b1;
        res.msg_kind   = ln_kind;
        for (int i = 0; i < 8; i++) res.value[i] = ln_fields[i];
      end
      expected_lines.push_back(row_typed ? row_want : res);
      clear_line_state();
    end else if (!ln_failed) begin
      if (ln_phase == PH_HEADER) match_header(c);
      else scan_body(c);
    end
  endtask

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(input logic [7:0] c, input logic le);
    int gap;
    gap = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.line_end <= le;
    do @(negedge clk); while (!in_ch.ready);
    predict_item(c, le);
    n_chars++;
    @(posedge clk);
  endtask

  task automatic send_line();
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    n_lines_sent++;
  endtask

  // Stop offering items until every queued result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_lines.size() != 0);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_blanks();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // One decimal field: mostly in range, with extremes, small values and a rare overflow.
  task automatic put_field(input logic [2:0] ft);
    longint lo;
    longint hi;
    longint v;
    int     mode;
    bit     signed_ft;
    signed_ft = (ft == FT_S16) || (ft == FT_S32);
    lo = 0;
    case (ft)
      FT_S16:  begin lo = -32768; hi = 32767; end
      FT_S32:  begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
      FT_FLAG: hi = 1;
      FT_MASK: hi = 7;
      default: hi = 65535;
    endcase
    mode = $urandom_range(0, 59);
    if (mode == 0) begin
      v = lo;
    end else if (mode == 1) begin
      v = hi;
    end else if (mode == 2) begin
      if ($urandom_range(0, 1))
        v = hi + 1 + longint'($urandom_range(0, 999)) * ((ft == FT_S32) ? 10000000 : 1);
      else
        v = lo - 1 - longint'($urandom_range(0, 999));
    end else if (mode < 8) begin
      v = $urandom_range(0, (hi < 9) ? hi : 9);
    end else if (ft == FT_S32) begin
      v = longint'(int'($urandom));
    end else begin
      v = lo + longint'($urandom_range(0, hi - lo));
    end
    if (v < 0) begin
      line_buf.push_back(CH_MINUS);
      v = -v;
    end else if (v == 0 && signed_ft && $urandom_range(0, 3) == 0) begin
      line_buf.push_back(CH_MINUS);
    end
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  // Mostly well-formed messages with random content; some broken, some pure noise.
  task automatic make_random_line();
    int style;
    int kind;
    int n;
    int p;
    line_buf.delete();
    style = $urandom_range(0, 19);
    if (style >= 18) begin
      n = $urandom_range(0, 30);
      repeat (n) begin
        if ($urandom_range(0, 1))
          line_buf.push_back(8'($urandom_range(0, 255)));
        else
          line_buf.push_back(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
      end
    end else begin
      kind = $urandom_range(0, NUM_KINDS - 1);
      for (int i = 0; i < HDR_LEN[kind]; i++) line_buf.push_back(HDR_TEXT[kind][i]);
      for (int f = 0; f < FIELD_COUNT[kind]; f++) begin
        if (f > 0) line_buf.push_back(CH_COMMA);
        put_blanks();
        put_field(FIELD_TYPE[kind][f]);
        put_blanks();
      end
      // Break a well-formed line in one of several ways.
      if (style >= 15) begin
        p = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 4))
          0: line_buf[p] = 8'($urandom_range(0, 255));
          1: while (line_buf.size() > p) void'(line_buf.pop_back());
          2: put_text(",5");
          3: line_buf.insert(p, 8'($urandom_range(0, 255)));
          default: line_buf[p] = NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)];
        endcase
      end
    end
  endtask

  task automatic add_row(input string text, input int nul_at, input bit typed,
                         input line_result_t want);
    line_row_t row;
    row.text   = text;
    row.nul_at = nul_at;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endtask

  // Compare one result with the oldest expectation, field by field.
  task automatic check_line(input line_result_t got);
    line_result_t want;
    n_checked++;
    if (expected_lines.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", n_checked));
    end else begin
      want = expected_lines.pop_front();
      if (got.line_valid !== want.line_valid)
        report_mismatch($sformatf("result %0d line_valid %0b, want %0b",
                                  n_checked, got.line_valid, want.line_valid));
      if (got.msg_kind !== want.msg_kind)
        report_mismatch($sformatf("result %0d msg_kind %0d, want %0d",
                                  n_checked, got.msg_kind, want.msg_kind));
      for (int i = 0; i < 8; i++) begin
        if (got.value[i] !== want.value[i])
          report_mismatch($sformatf("result %0d value_%0d %0d, want %0d", n_checked, i,
                                    $signed(got.value[i]), $signed(want.value[i])));
      end
      if (want.line_valid) n_kind_ok[want.msg_kind]++;
      else n_rejected++;
    end
  endtask

  // Result side: random stall before each item, plus the long hold-off.
  initial begin
    line_result_t got;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (n_checked % 8 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      got.line_valid = out_ch.line_valid;
      got.msg_kind   = out_ch.msg_kind;
      got.value[0]   = out_ch.value_0;
      got.value[1]   = out_ch.value_1;
      got.value[2]   = out_ch.value_2;
      got.value[3]   = out_ch.value_3;
      got.value[4]   = out_ch.value_4;
      got.value[5]   = out_ch.value_5;
      got.value[6]   = out_ch.value_6;
      got.value[7]   = out_ch.value_7;
      check_line(got);
      @(posedge clk);
    end
  end

  // Long receiver hold-off, so the result register fills and the input stalls.
  initial begin
    wait (start_hold);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (1500) @(posedge clk);
    @(negedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog.
  initial begin
    #3_200_000;
    $display("FAIL csv_telemetry_line_parser");
    $finish;
  end

  // Stimulus: reset, directed lines, random lines, then drain and report.
  initial begin
    int rand_lines;
    int w;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.char_in  <= 8'h00;
    in_ch.line_end <= 1'b0;
    rand_lines = 0;
    row_typed  = 1'b0;
    clear_line_state();

    // Directed lines: extremes, every kind and the special cases.
    add_row("", -1, 1'b1, '0);
    add_row("VSOL_OK,0", -1, 1'b1, '{1'b1, KIND_SP_ACK, '{0, 0, 0, 0, 0, 0, 0, 0}});
    add_row("VSOL_OK,65535", -1, 1'b1,
            '{1'b1, KIND_SP_ACK, '{65535, 0, 0, 0, 0, 0, 0, 0}});
    add_row("VSOL_OK,65536", -1, 1'b1, '0);
    add_row("VSOL,65535,1,-32768,32767", -1, 1'b1,
            '{1'b1, KIND_SETPOINT, '{65535, 1, -32768, 32767, 0, 0, 0, 0}});
    add_row("VSOL,0,2,0,0", -1, 1'b1, '0);
    add_row("VSOL,0,1,32768,0", -1, 1'b1, '0);
    add_row("VSOL,0,0,0,-32769", -1, 1'b1, '0);
    add_row("VSOL, 12 ,0 , -0\t,\t007 \t", -1, 1'b0, '0);
    add_row("VIST,65535,-32768,32767,-1,1,-2147483648,2147483647", -1, 1'b1,
            '{1'b1, KIND_ACTUAL,
              '{65535, -32768, 32767, -1, 1, 32'h8000_0000, 32'h7fff_ffff, 0}});
    add_row("VIST,1,2,3,4,5,2147483648,6", -1, 1'b1, '0);
    add_row("VIST,1,2,3,4,5,6,-2147483649", -1, 1'b1, '0);
    // A magnitude that would wrap a 32-bit accumulator.
    add_row("VIST,1,2,3,4,5,42949672960,6", -1, 1'b1, '0);
    add_row("US,65535,0,1,2,7,65535,3,4", -1, 1'b1,
            '{1'b1, KIND_ULTRA, '{65535, 0, 1, 2, 7, 65535, 3, 4}});
    add_row("US,1,2,3,4,8,5,6,7", -1, 1'b1, '0);
    add_row("US,1,2,3,4,5,6,7,8,9", -1, 1'b1, '0);
    add_row("US,1,2,3", -1, 1'b1, '0);
    add_row("VSOL,1,0,- 5,0", -1, 1'b1, '0);
    add_row("VSOL,-1,0,0,0", -1, 1'b1, '0);
    add_row("VSOL_OK,5,", -1, 1'b1, '0);
    add_row("VSOL_OK,12", 10, 1'b1, '0);
    add_row("VSOL_OK ,1", -1, 1'b1, '0);
    add_row("VSOL_OK,1 2", -1, 1'b1, '0);
    add_row("VSOL_OK,0000012   ", -1, 1'b0, '0);
    add_row("VIST,\t1, -2,3 ,-4,5,-6 , 7\t", -1, 1'b0, '0);
    add_row("VSOL,1,1,-00,+5", -1, 1'b1, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      line_buf.delete();
      put_text(dir_rows[i].text);
      if (dir_rows[i].nul_at >= 0) line_buf.insert(dir_rows[i].nul_at, 8'h00);
      row_typed = dir_rows[i].typed;
      row_want  = dir_rows[i].want;
      send_line();
    end
    row_typed = 1'b0;
    drain_results();

    // Random lines until the whole run has sent about 1200 items.
    while (n_chars < 1200) begin
      make_random_line();
      send_line();
      rand_lines++;
      if (rand_lines == 8) start_hold = 1'b1;
      if (rand_lines == 20) drain_results();
    end

    // Let the last results come back, with a bound.
    in_ch.valid <= 1'b0;
    for (w = 0; w < 5000 && expected_lines.size() != 0; w++) @(posedge clk);
    if (expected_lines.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_lines.size()));
    repeat (4) @(posedge clk);

    $display("Covered %0d directed and %0d random lines, %0d characters, %0d results checked.",
             dir_rows.size(), rand_lines, n_chars, n_checked);
    $display("Accepted lines: setpoint %0d, ack %0d, actual %0d, ultrasonic %0d; rejected %0d.",
             n_kind_ok[KIND_SETPOINT], n_kind_ok[KIND_SP_ACK], n_kind_ok[KIND_ACTUAL],
             n_kind_ok[KIND_ULTRA], n_rejected);
    if (n_mismatch == 0) begin
      $display("PASS csv_telemetry_line_parser");
    end else begin
      $display("FAIL csv_telemetry_line_parser");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/csvp_pkg.sv
sv/csvp_in_if.sv
sv/csvp_out_if.sv
sv/csv_telemetry_line_parser.sv
tb/csv_telemetry_line_parser_tb.sv
